// ===== hdl/pgsm_pkg.sv =====
// Package for the pulse gap speed meter: widths, reset constants, FSM state,
// and the command/status structs between controller and datapath.
// No dependencies.
package pgsm_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int WORD_WIDTH  = 32;
   localparam int EXT_WIDTH   = (COUNT_WIDTH > WORD_WIDTH) ? COUNT_WIDTH : WORD_WIDTH + 1;
   localparam int DIV_STEPS   = WORD_WIDTH;
   localparam int STEP_WIDTH  = $clog2(DIV_STEPS);

   localparam logic [WORD_WIDTH-1:0]  NUM_RESET = WORD_WIDTH'(14482286);
   localparam logic [WORD_WIDTH-1:0]  WORD_MAX  = '1;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic accept;    // take the input word this cycle
      logic step;      // one divider iteration
      logic load_out;  // copy result into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic emit;      // current input word is an armed rising edge
      logic div_last;  // divider on its final iteration
   } dp_status_type;

endpackage

// ===== hdl/pgsm_datapath.sv =====
// Datapath: edge detect, saturating tick counter, config register,
// bit-serial restoring divider and result registers.
// Depends on pgsm_pkg.
module pgsm_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [pgsm_pkg::WORD_WIDTH-1:0]  csr_wr_data,
   input  logic                             req_pin_level,
   input  pgsm_pkg::ctrl_cmd_type           cmd,
   output pgsm_pkg::dp_status_type          status,
   output logic [pgsm_pkg::WORD_WIDTH-1:0]  rsp_speed_q8,
   output logic [pgsm_pkg::WORD_WIDTH-1:0]  rsp_low_ticks,
   output logic                             rsp_saturated
);
   import pgsm_pkg::*;

   logic [WORD_WIDTH-1:0]  numerator_ff, numerator_in;
   logic                   prev_level_ff, prev_level_in;
   logic                   await_rising_ff, await_rising_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in, tick_inc;
   logic [WORD_WIDTH-1:0]  low_ff, low_in;
   logic                   sat_ff, sat_in;
   logic [WORD_WIDTH-1:0]  quot_ff, quot_in;
   logic [WORD_WIDTH-1:0]  rem_ff, rem_in;
   logic [WORD_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [WORD_WIDTH-1:0]  speed_out_ff, speed_out_in;
   logic [WORD_WIDTH-1:0]  low_out_ff, low_out_in;
   logic                   sat_out_ff, sat_out_in;

   logic                   rise, fall, emit, clear;
   logic [EXT_WIDTH-1:0]   cnt_ext;
   logic                   clipped;
   logic [WORD_WIDTH-1:0]  low_now;
   logic                   sat_now;
   logic [WORD_WIDTH:0]    rem_sh;
   logic [WORD_WIDTH+1:0]  diff;
   logic                   borrow;

   always_comb begin
      rise  = !prev_level_ff && req_pin_level;
      fall  = prev_level_ff && !req_pin_level;
      clear = fall && !await_rising_ff;
      emit  = rise && await_rising_ff;

      tick_inc = (tick_ff == CNT_MAX) ? tick_ff : tick_ff + COUNT_WIDTH'(1);
      cnt_ext  = EXT_WIDTH'(tick_inc);
      clipped  = cnt_ext > EXT_WIDTH'(WORD_MAX);
      low_now  = clipped ? WORD_MAX : cnt_ext[WORD_WIDTH-1:0];
      sat_now  = (tick_inc == '0) || (tick_inc == CNT_MAX) || clipped;

      // restoring divide, one quotient bit per step; divide by zero
      // never borrows and so yields all ones, which is the saturated speed
      rem_sh = {rem_ff, quot_ff[WORD_WIDTH-1]};
      diff   = {1'b0, rem_sh} - {2'b00, divisor_ff};
      borrow = diff[WORD_WIDTH+1];

      numerator_in    = csr_wr_en ? csr_wr_data : numerator_ff;
      prev_level_in   = prev_level_ff;
      await_rising_in = await_rising_ff;
      tick_in         = tick_ff;
      low_in          = low_ff;
      sat_in          = sat_ff;
      quot_in         = quot_ff;
      rem_in          = rem_ff;
      divisor_in      = divisor_ff;
      step_in         = step_ff;
      speed_out_in    = speed_out_ff;
      low_out_in      = low_out_ff;
      sat_out_in      = sat_out_ff;

      if (cmd.accept) begin
         prev_level_in = req_pin_level;
         if (clear) begin
            tick_in         = '0;
            await_rising_in = 1'b1;
         end else begin
            tick_in = tick_inc;
            if (emit) begin
               await_rising_in = 1'b0;
               low_in          = low_now;
               sat_in          = sat_now;
               divisor_in      = low_now;
               quot_in         = numerator_ff;
               rem_in          = '0;
               step_in         = '0;
            end
         end
      end

      if (cmd.step) begin
         rem_in  = borrow ? rem_sh[WORD_WIDTH-1:0] : diff[WORD_WIDTH-1:0];
         quot_in = {quot_ff[WORD_WIDTH-2:0], !borrow};
         step_in = step_ff + STEP_WIDTH'(1);
      end

      if (cmd.load_out) begin
         speed_out_in = quot_ff;
         low_out_in   = low_ff;
         sat_out_in   = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         numerator_ff    <= NUM_RESET;
         prev_level_ff   <= 1'b0;
         await_rising_ff <= 1'b1;
         tick_ff         <= '0;
      end else begin
         numerator_ff    <= numerator_in;
         prev_level_ff   <= prev_level_in;
         await_rising_ff <= await_rising_in;
         tick_ff         <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff       <= low_in;
      sat_ff       <= sat_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      step_ff      <= step_in;
      speed_out_ff <= speed_out_in;
      low_out_ff   <= low_out_in;
      sat_out_ff   <= sat_out_in;
   end

   assign status.emit     = emit;
   assign status.div_last = (step_ff == STEP_WIDTH'(DIV_STEPS - 1));

   assign rsp_speed_q8  = speed_out_ff;
   assign rsp_low_ticks = low_out_ff;
   assign rsp_saturated = sat_out_ff;

endmodule

// ===== hdl/pgsm_ctrl.sv =====
// Controller FSM: sequences input acceptance, divider steps and output load,
// and owns the output valid flag.
// Depends on pgsm_pkg.
module pgsm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  pgsm_pkg::dp_status_type  status,
   output pgsm_pkg::ctrl_cmd_type   cmd
);
   import pgsm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.emit) state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            // quotient is complete once the last step is registered, so the
            // DIVIDE exit always goes through a load from the finished quotient
            if (status.div_last) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/pulse_gap_speed_meter.sv =====
// Top level of the pulse gap speed meter: ties the controller to the datapath.
// Depends on pgsm_pkg, pgsm_ctrl, pgsm_datapath.
//
//  channel | ports                                        | dir | moves
//  --------+----------------------------------------------+-----+------------------------
//  req     | req_valid, req_stall, req_pin_level          | in  | one timer tick word
//  rsp     | rsp_valid, rsp_stall, rsp_speed_q8,          | out | one speed word per
//          | rsp_low_ticks, rsp_saturated                 |     | armed rising edge
//  csr     | csr_wr_en, csr_wr_data                       | in  | speed numerator
//
// A tick word that produces no result leaves the block idle; back-to-back ticks are taken.
// An armed rising edge starts the bit-serial divider: the accept, the divide steps
// (one quotient bit each), then the load, and no new word is taken before the load.
// If the output word is still stalled when the quotient is ready, the block waits
// in a hold state; req_stall stays high until the result is loaded.
// Reset (synchronous, high) sets prev level low, arms for a rising edge, clears
// the tick counter and loads the default numerator.
module pulse_gap_speed_meter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [pgsm_pkg::WORD_WIDTH-1:0]  csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_pin_level,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [pgsm_pkg::WORD_WIDTH-1:0]  rsp_speed_q8,
   output logic [pgsm_pkg::WORD_WIDTH-1:0]  rsp_low_ticks,
   output logic                             rsp_saturated
);
   import pgsm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencing: accept / divide / hold
   pgsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // counter, edge logic, divider and output word
   pgsm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_pin_level (req_pin_level),
      .cmd           (cmd),
      .status        (status),
      .rsp_speed_q8  (rsp_speed_q8),
      .rsp_low_ticks (rsp_low_ticks),
      .rsp_saturated (rsp_saturated)
   );

endmodule
